[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/scu_pkg.sv]
// ----------------------------------------------------------------------------
// scu_pkg
// shared types and codes of the stack calculator unit
// ----------------------------------------------------------------------------
package scu_pkg;

	localparam int DEF_STACK_DEPTH = 8;
	localparam int DEF_WORD_BITS   = 32;

	// operation codes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_POP  = 3'd1;
	localparam logic [2:0] OP_DUP  = 3'd2;
	localparam logic [2:0] OP_ADD  = 3'd3;
	localparam logic [2:0] OP_SUB  = 3'd4;
	localparam logic [2:0] OP_MUL  = 3'd5;
	localparam logic [2:0] OP_DIV  = 3'd6;

	// status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_OVER  = 2'd1;
	localparam logic [1:0] STS_UNDER = 2'd2;
	localparam logic [1:0] STS_DIVZ  = 2'd3;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] popped_value;
		logic signed [31:0] top_value;
		logic [3:0]         depth;
		logic [1:0]         status;
	} rsp_t;

endpackage

[sv/stack_calculator_unit.sv]
// ----------------------------------------------------------------------------
// stack_calculator_unit
// rpn stack calculator with bit-serial multiply and divide
// ----------------------------------------------------------------------------
// Each command beat carries one operation on a stack of STACK_DEPTH signed
// words and yields exactly one response beat with the popped word, the new
// top, the depth and a status. Push, pop, duplicate, add, subtract and any
// command that fails its depth check go through accept, execute and load
// response before the next command is accepted. Multiply and divide insert
// serial steps between execute and load response, one bit per cycle:
// multiply as a shift-add over the multiplier bits, divide as a restoring
// division that develops one quotient bit per cycle, followed by a sign fix
// and a second stack write for the remainder.
// The stack lives in a small memory with one write port and two registered
// read ports that always look at the top two entries. A response waiting in
// the output register does not block the next command; the unit only stalls
// at its final step until the response register is free.
// ----------------------------------------------------------------------------
module stack_calculator_unit #(
	parameter int STACK_DEPTH = scu_pkg::DEF_STACK_DEPTH,
	parameter int WORD_BITS   = scu_pkg::DEF_WORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  scu_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output scu_pkg::rsp_t rsp
);

	localparam int W  = WORD_BITS;
	localparam int IW = $clog2(STACK_DEPTH);
	localparam int FW = $clog2(STACK_DEPTH + 1);
	localparam int CW = $clog2(WORD_BITS);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_EXEC = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_FIX  = 7'b0010000,
		ST_WR2  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// stack storage and its registered read ports
	logic [W-1:0]  mem [STACK_DEPTH];
	logic [W-1:0]  rd_top_q;
	logic [W-1:0]  rd_sec_q;
	logic          we;
	logic [IW-1:0] waddr;
	logic [W-1:0]  wdata;

	// fill count and derived indexes
	logic [FW-1:0] fill_q;
	logic [IW-1:0] top_idx;
	logic [IW-1:0] sec_idx;
	logic [IW-1:0] push_idx;
	logic          empty;
	logic          full;
	logic          few;

	// captured command
	logic [2:0]    op_q;
	logic [W-1:0]  imm_q;

	// serial multiply registers
	logic [W-1:0]  mcand_q;
	logic [W-1:0]  mplier_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  acc_next;

	// serial divide registers
	logic [W-1:0]  dq_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  ub_q;
	logic          qneg_q;
	logic          rneg_q;
	logic [W:0]    shifted;
	logic          ge;
	logic [W-1:0]  rem_next;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;
	logic [W-1:0]  q_fix;
	logic [W-1:0]  r_fix;

	logic [W-1:0]  arith;
	logic [W-1:0]  cur_top;
	logic [CW-1:0] cnt_q;

	// response staging and output register
	scu_pkg::rsp_t res_q;
	scu_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;
	logic          slot_free;

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	assign top_idx  = IW'(fill_q - FW'(1));
	assign sec_idx  = IW'(fill_q - FW'(2));
	assign push_idx = IW'(fill_q);
	assign empty    = (fill_q == '0);
	assign full     = (fill_q == FW'(STACK_DEPTH));
	assign few      = (fill_q < FW'(2));

	// top as seen before the operation, zero on an empty stack
	assign cur_top = empty ? '0 : rd_top_q;

	// combinational add or subtract of below and top
	assign arith = (op_q == scu_pkg::OP_SUB) ? (rd_sec_q - rd_top_q) : (rd_sec_q + rd_top_q);

	// shift-add step, multiplier consumed lsb first
	assign acc_next = mplier_q[0] ? (acc_q + mcand_q) : acc_q;

	// restoring divide step, dividend consumed msb first
	assign shifted  = {rem_q, dq_q[W-1]};
	assign ge       = (shifted >= {1'b0, ub_q});
	assign rem_next = ge ? W'(shifted - {1'b0, ub_q}) : W'(shifted);

	// magnitudes of the operands and signed results
	assign mag_a = rd_sec_q[W-1] ? (W'(0) - rd_sec_q) : rd_sec_q;
	assign mag_b = rd_top_q[W-1] ? (W'(0) - rd_top_q) : rd_top_q;
	assign q_fix = qneg_q ? (W'(0) - dq_q) : dq_q;
	assign r_fix = rneg_q ? (W'(0) - rem_q) : rem_q;

	// stack write port
	always_comb begin
		we    = 1'b0;
		waddr = push_idx;
		wdata = imm_q;
		case (state_q)
			ST_EXEC: begin
				case (op_q)
					scu_pkg::OP_PUSH: begin
						we = !full;
					end
					scu_pkg::OP_DUP: begin
						we    = !empty && !full;
						wdata = rd_top_q;
					end
					scu_pkg::OP_ADD, scu_pkg::OP_SUB: begin
						we    = !few;
						waddr = sec_idx;
						wdata = arith;
					end
					default: begin
						we = 1'b0;
					end
				endcase
			end
			ST_MUL: begin
				we    = (cnt_q == '0);
				waddr = sec_idx;
				wdata = acc_next;
			end
			ST_FIX: begin
				we    = 1'b1;
				waddr = sec_idx;
				wdata = q_fix;
			end
			ST_WR2: begin
				we    = 1'b1;
				waddr = top_idx;
				wdata = rem_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_top_q <= mem[top_idx];
		rd_sec_q <= mem[sec_idx];
	end

	// control: sequencer, fill count, bit counter, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (op_q)
						scu_pkg::OP_PUSH: begin
							if (!full) begin
								fill_q <= fill_q + FW'(1);
							end
						end
						scu_pkg::OP_POP: begin
							if (!empty) begin
								fill_q <= fill_q - FW'(1);
							end
						end
						scu_pkg::OP_DUP: begin
							if (!empty && !full) begin
								fill_q <= fill_q + FW'(1);
							end
						end
						scu_pkg::OP_ADD, scu_pkg::OP_SUB: begin
							if (!few) begin
								fill_q <= fill_q - FW'(1);
							end
						end
						scu_pkg::OP_MUL: begin
							if (!few) begin
								state_q <= ST_MUL;
								cnt_q   <= CW'(W - 1);
							end
						end
						scu_pkg::OP_DIV: begin
							if (!few && rd_top_q != '0) begin
								state_q <= ST_DIV;
								cnt_q   <= CW'(W - 1);
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_MUL: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						fill_q  <= fill_q - FW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					state_q <= ST_WR2;
				end
				ST_WR2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			op_q  <= cmd.op;
			imm_q <= W'($unsigned(cmd.value));
		end
		if (state_q == ST_DONE && slot_free) begin
			rsp_q <= res_q;
		end
		case (state_q)
			ST_EXEC: begin
				// operands for the serial units, used only when one starts
				mcand_q  <= rd_sec_q;
				mplier_q <= rd_top_q;
				acc_q    <= '0;
				dq_q     <= mag_a;
				rem_q    <= '0;
				ub_q     <= mag_b;
				qneg_q   <= rd_sec_q[W-1] ^ rd_top_q[W-1];
				rneg_q   <= rd_sec_q[W-1];

				// unchanged stack unless an arm below says otherwise
				res_q.popped_value <= '0;
				res_q.top_value    <= 32'(cur_top);
				res_q.depth        <= 4'(fill_q);
				res_q.status       <= scu_pkg::STS_OK;
				case (op_q)
					scu_pkg::OP_PUSH: begin
						if (full) begin
							res_q.status <= scu_pkg::STS_OVER;
						end else begin
							res_q.top_value <= 32'(imm_q);
							res_q.depth     <= 4'(fill_q + FW'(1));
						end
					end
					scu_pkg::OP_POP: begin
						if (empty) begin
							res_q.status <= scu_pkg::STS_UNDER;
						end else begin
							res_q.popped_value <= 32'(rd_top_q);
							res_q.top_value    <= few ? '0 : 32'(rd_sec_q);
							res_q.depth        <= 4'(fill_q - FW'(1));
						end
					end
					scu_pkg::OP_DUP: begin
						if (empty) begin
							res_q.status <= scu_pkg::STS_UNDER;
						end else if (full) begin
							res_q.status <= scu_pkg::STS_OVER;
						end else begin
							res_q.depth <= 4'(fill_q + FW'(1));
						end
					end
					scu_pkg::OP_ADD, scu_pkg::OP_SUB: begin
						if (few) begin
							res_q.status <= scu_pkg::STS_UNDER;
						end else begin
							res_q.top_value <= 32'(arith);
							res_q.depth     <= 4'(fill_q - FW'(1));
						end
					end
					scu_pkg::OP_MUL: begin
						if (few) begin
							res_q.status <= scu_pkg::STS_UNDER;
						end
					end
					scu_pkg::OP_DIV: begin
						if (few) begin
							res_q.status <= scu_pkg::STS_UNDER;
						end else if (rd_top_q == '0) begin
							res_q.status <= scu_pkg::STS_DIVZ;
						end
					end
					default: begin
						res_q.status <= scu_pkg::STS_OK;
					end
				endcase
			end
			ST_MUL: begin
				acc_q    <= acc_next;
				mcand_q  <= {mcand_q[W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[W-1:1]};
				if (cnt_q == '0) begin
					res_q.top_value <= 32'(acc_next);
					res_q.depth     <= 4'(fill_q - FW'(1));
				end
			end
			ST_DIV: begin
				dq_q  <= {dq_q[W-2:0], ge};
				rem_q <= rem_next;
			end
			ST_FIX: begin
				// quotient goes below now, remainder on top next cycle
				rem_q           <= r_fix;
				res_q.top_value <= 32'(r_fix);
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

[sv/scu_checker.sv]
// ----------------------------------------------------------------------------
// scu_checker
// port-level checks of the stack calculator unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scu_checker #(
	parameter int STACK_DEPTH = scu_pkg::DEF_STACK_DEPTH
) (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input scu_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input scu_pkg::rsp_t rsp
);

	logic cmd_beat;

	assign cmd_beat = cmd_valid && cmd_ready;

	// depth never exceeds the stack size
	`ASSERT_SAME(a_depth_range, clk, arst_n, rsp_valid && STACK_DEPTH < 16, 32'(rsp.depth) <= STACK_DEPTH, "depth beyond stack size")

	// an empty stack reports a zero top
	`ASSERT_SAME(a_empty_top, clk, arst_n, rsp_valid && STACK_DEPTH < 16 && rsp.depth == 4'd0, rsp.top_value == '0, "nonzero top on empty stack")

	// a popped word only comes with a good status
	`ASSERT_SAME(a_pop_ok, clk, arst_n, rsp_valid && rsp.popped_value != '0, rsp.status == scu_pkg::STS_OK, "popped word with error status")

	// the unit takes no new command in the cycle right after one
	`ASSERT_NEXT(a_no_back2back, clk, arst_n, cmd_beat, !cmd_ready, "command taken on consecutive cycles")

	// a stalled response beat holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

endmodule

bind stack_calculator_unit scu_checker #(.STACK_DEPTH(STACK_DEPTH)) u_scu_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rpn stack calculator unit
// ----------------------------------------------------------------------------
// Drives command beats through a valid/ready channel and checks every
// response beat against a behavioral stack model kept inside the bench. A
// short directed run covers empty-stack and full-stack errors, wraparound
// arithmetic, divide by zero, the most negative word divided by minus one and
// the unused op code. Random traffic follows in four handshake phases: none,
// sender gaps, response back-pressure and both together.
// ----------------------------------------------------------------------------
module tb;

	localparam int          STACK_DEPTH  = scu_pkg::DEF_STACK_DEPTH;
	localparam int          CLK_HALF     = 5;
	localparam int          RESET_CYCLES = 8;
	// divide is the slowest command, so this margin covers it
	localparam int          DRAIN_CYCLES = 64;
	localparam int          CYCLE_LIMIT  = 1_000_000;
	localparam logic [2:0]  OP_UNUSED    = 3'd7;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_ready;
	scu_pkg::cmd_t cmd       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	scu_pkg::rsp_t rsp;

	// stack model state, updated at the edge a command beat is accepted
	logic signed [31:0] model_stack [STACK_DEPTH];
	int                 model_fill = 0;

	scu_pkg::rsp_t expected_results [$];
	scu_pkg::rsp_t want_rsp;
	int            err_count     = 0;
	int            cycle_count   = 0;
	int            cmd_idle_pct  = 0;
	int            rsp_stall_pct = 0;

	stack_calculator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// hard stop in case the unit hangs on either channel
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, expected_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// response back-pressure, redrawn every cycle
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// applies one command to the model stack and returns the response it owes
	function automatic scu_pkg::rsp_t apply_stack_op(input scu_pkg::cmd_t c);
		scu_pkg::rsp_t      r;
		logic signed [31:0] a;
		logic signed [31:0] b;
		longint             mag_a;
		longint             mag_b;
		longint             quo;
		longint             rem;
		int                 n;
		r = '0;
		r.status = scu_pkg::STS_OK;
		n = model_fill;
		case (c.op)
			scu_pkg::OP_PUSH: begin
				if (n >= STACK_DEPTH) r.status = scu_pkg::STS_OVER;
				else begin
					model_stack[n] = c.value;
					n++;
				end
			end
			scu_pkg::OP_POP: begin
				if (n == 0) r.status = scu_pkg::STS_UNDER;
				else begin
					n--;
					r.popped_value = model_stack[n];
				end
			end
			scu_pkg::OP_DUP: begin
				// underflow wins over overflow
				if (n == 0) r.status = scu_pkg::STS_UNDER;
				else if (n >= STACK_DEPTH) r.status = scu_pkg::STS_OVER;
				else begin
					model_stack[n] = model_stack[n-1];
					n++;
				end
			end
			scu_pkg::OP_ADD, scu_pkg::OP_SUB, scu_pkg::OP_MUL, scu_pkg::OP_DIV: begin
				if (n < 2) r.status = scu_pkg::STS_UNDER;
				else begin
					b = model_stack[n-1];
					a = model_stack[n-2];
					case (c.op)
						scu_pkg::OP_ADD: begin
							model_stack[n-2] = a + b;
							n--;
						end
						scu_pkg::OP_SUB: begin
							model_stack[n-2] = a - b;
							n--;
						end
						scu_pkg::OP_MUL: begin
							model_stack[n-2] = a * b;
							n--;
						end
						default: begin
							if (b == 0) r.status = scu_pkg::STS_DIVZ;
							else begin
								// magnitudes in 64 bits so the most negative word is safe
								mag_a = (a < 0) ? -longint'(a) : longint'(a);
								mag_b = (b < 0) ? -longint'(b) : longint'(b);
								quo = mag_a / mag_b;
								rem = mag_a % mag_b;
								if ((a < 0) != (b < 0)) quo = -quo;
								if (a < 0) rem = -rem;
								model_stack[n-2] = quo[31:0];
								model_stack[n-1] = rem[31:0];
							end
						end
					endcase
				end
			end
			default: ; // unused code leaves everything as it is
		endcase
		model_fill = n;
		r.top_value = (n == 0) ? 32'sd0 : model_stack[n-1];
		r.depth = n[3:0];
		return r;
	endfunction

	function automatic scu_pkg::cmd_t make_cmd(input logic [2:0] op,
		input logic signed [31:0] value);
		scu_pkg::cmd_t c;
		c.op = op;
		c.value = value;
		return c;
	endfunction

	// operand mix: full random words, small numbers, zero and the extremes
	function automatic logic signed [31:0] random_word();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40) return $urandom;
		else if (roll < 70) return int'($urandom_range(40)) - 20;
		else if (roll < 80) return 32'sd0;
		case ($urandom_range(3))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	// mostly legal commands for the current depth, with some error noise;
	// depth drifts upward so the full stack is reached regularly
	function automatic scu_pkg::cmd_t pick_random_cmd();
		scu_pkg::cmd_t c;
		int            roll;
		int            n;
		n = model_fill;
		roll = $urandom_range(99);
		c.value = random_word();
		if (roll < 8) c.op = 3'($urandom_range(7));
		else if (n == 0) c.op = scu_pkg::OP_PUSH;
		else if (n == 1) c.op = (roll < 70) ? scu_pkg::OP_PUSH :
			(roll < 85) ? scu_pkg::OP_DUP : scu_pkg::OP_POP;
		else if (n >= STACK_DEPTH && roll < 85) begin
			case ($urandom_range(4))
				0: c.op = scu_pkg::OP_POP;
				1: c.op = scu_pkg::OP_ADD;
				2: c.op = scu_pkg::OP_SUB;
				3: c.op = scu_pkg::OP_MUL;
				default: c.op = scu_pkg::OP_DIV;
			endcase
		end
		else if (roll < 45) c.op = scu_pkg::OP_PUSH;
		else if (roll < 53) c.op = scu_pkg::OP_DUP;
		else if (roll < 63) c.op = scu_pkg::OP_POP;
		else if (roll < 72) c.op = scu_pkg::OP_ADD;
		else if (roll < 81) c.op = scu_pkg::OP_SUB;
		else if (roll < 90) c.op = scu_pkg::OP_MUL;
		else c.op = scu_pkg::OP_DIV;
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h expected %h", $time, what, got, want);
		err_count++;
	endtask

	// one command beat; the expectation is queued at the accepting edge
	task automatic send_cmd(input scu_pkg::cmd_t c);
		@(negedge clk);
		while ($urandom_range(99) < cmd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		expected_results.push_back(apply_stack_op(c));
	endtask

	// stop sending, then wait out every owed response plus the latency margin
	task automatic wait_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// response checker: every accepted beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat", rsp.top_value, 32'd0);
			end else begin
				want_rsp = expected_results.pop_front();
				if (rsp.popped_value !== want_rsp.popped_value)
					report_mismatch("popped_value", rsp.popped_value, want_rsp.popped_value);
				if (rsp.top_value !== want_rsp.top_value)
					report_mismatch("top_value", rsp.top_value, want_rsp.top_value);
				if (rsp.depth !== want_rsp.depth)
					report_mismatch("depth", 32'(rsp.depth), 32'(want_rsp.depth));
				if (rsp.status !== want_rsp.status)
					report_mismatch("status", 32'(rsp.status), 32'(want_rsp.status));
			end
		end
	end

	// corner cases in one walk from an empty stack to a full one
	task automatic test_directed_edges();
		cmd_idle_pct = 0;
		rsp_stall_pct = 0;
		// errors on the empty stack, then the unused code
		send_cmd(make_cmd(scu_pkg::OP_POP, random_word()));
		send_cmd(make_cmd(scu_pkg::OP_DUP, random_word()));
		send_cmd(make_cmd(scu_pkg::OP_ADD, random_word()));
		send_cmd(make_cmd(OP_UNUSED, random_word()));
		send_cmd(make_cmd(scu_pkg::OP_PUSH, 32'sh7fff_ffff));
		// binary op with a single entry
		send_cmd(make_cmd(scu_pkg::OP_DIV, random_word()));
		// largest word plus one wraps to the most negative
		send_cmd(make_cmd(scu_pkg::OP_PUSH, 32'sd1));
		send_cmd(make_cmd(scu_pkg::OP_ADD, random_word()));
		// most negative over minus one: quotient wraps, remainder zero
		send_cmd(make_cmd(scu_pkg::OP_PUSH, -32'sd1));
		send_cmd(make_cmd(scu_pkg::OP_DIV, random_word()));
		// zero divisor now on top
		send_cmd(make_cmd(scu_pkg::OP_DIV, random_word()));
		send_cmd(make_cmd(scu_pkg::OP_POP, random_word()));
		// product wraps
		send_cmd(make_cmd(scu_pkg::OP_PUSH, 32'sd3));
		send_cmd(make_cmd(scu_pkg::OP_MUL, random_word()));
		// negative dividend truncates toward zero
		send_cmd(make_cmd(scu_pkg::OP_PUSH, -32'sd7));
		send_cmd(make_cmd(scu_pkg::OP_PUSH, 32'sd2));
		send_cmd(make_cmd(scu_pkg::OP_DIV, random_word()));
		send_cmd(make_cmd(scu_pkg::OP_SUB, random_word()));
		// fill to the top, then overflow both ways
		repeat (STACK_DEPTH - 2) send_cmd(make_cmd(scu_pkg::OP_DUP, random_word()));
		send_cmd(make_cmd(scu_pkg::OP_PUSH, 32'sh8000_0000));
		send_cmd(make_cmd(scu_pkg::OP_DUP, random_word()));
		send_cmd(make_cmd(OP_UNUSED, random_word()));
		wait_drained();
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		cmd_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (count) send_cmd(pick_random_cmd());
		wait_drained();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_edges();
		test_random_traffic(325, 0, 0);
		test_random_traffic(325, 72, 0);
		test_random_traffic(325, 0, 72);
		test_random_traffic(325, 19, 19);

		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
